// ===== rtl/afx_pkg.sv =====
package afx_pkg;

    localparam int CMD_W     = 3;
    localparam int IDX_W     = 4;
    localparam int FWD_DEPTH = 12;
    localparam int INV_DEPTH = 9;
    localparam int FWD_COLS  = 4;
    localparam int INV_COLS  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_FWD = 3'd0,
        CMD_LOAD_INV = 3'd1,
        CMD_POINT    = 3'd2,
        CMD_VECTOR   = 3'd3,
        CMD_NORMAL   = 3'd4,
        CMD_RAY      = 3'd5
    } cmd_t;

    // per-stage capture enables of the dot-product lanes
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } afx_en_t;

endpackage

// ===== rtl/afx_lane.sv =====
// One output component: three products plus an optional translation term,
// summed exactly, shifted down by FRAC_BITS and saturated.
module afx_lane
    import afx_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int WORD_WIDTH = 32
)
(
    input  logic                         clk,
    input  afx_en_t                      en,
    input  logic [2:0][WORD_WIDTH-1:0]   coef,
    input  logic [2:0][WORD_WIDTH-1:0]   vec,
    input  logic [WORD_WIDTH-1:0]        trans,
    input  logic                         use_t,
    output logic [WORD_WIDTH-1:0]        res
);

    localparam int PW = 2 * WORD_WIDTH;
    localparam int SW = 2 * WORD_WIDTH + 2;

    logic signed [PW-1:0] prod_reg [3];
    logic signed [SW-1:0] trans_reg;
    logic signed [SW-1:0] pair_a_reg;
    logic signed [SW-1:0] pair_b_reg;
    logic signed [SW-1:0] sum_reg;

    logic signed [SW-1:0]           shifted;
    logic [SW-WORD_WIDTH:0]         upper;
    logic                           fits;

    always_ff @(posedge clk)
    begin
        if (en.en1)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= PW'(signed'(coef[k])) * PW'(signed'(vec[k]));
            end
            trans_reg <= use_t ? (SW'(signed'(trans)) <<< FRAC_BITS) : '0;
        end
        if (en.en2)
        begin
            pair_a_reg <= SW'(prod_reg[0]) + SW'(prod_reg[1]);
            pair_b_reg <= SW'(prod_reg[2]) + trans_reg;
        end
        if (en.en3)
        begin
            sum_reg <= pair_a_reg + pair_b_reg;
        end
    end

    // floor shift, then clamp when the upper bits are not a sign run
    always_comb
    begin
        shifted = sum_reg >>> FRAC_BITS;
        upper   = shifted[SW-1:WORD_WIDTH-1];
        fits    = (&upper) || !(|upper);
        if (fits)
        begin
            res = shifted[WORD_WIDTH-1:0];
        end
        else if (shifted[SW-1])
        begin
            res = {1'b1, {(WORD_WIDTH-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(WORD_WIDTH-1){1'b1}}};
        end
    end

endmodule

// ===== rtl/affine_transform_apply.sv =====
// Affine transform of points, vectors, normals and rays in signed fixed point.
// A result request passes the three lane stages and then the output register,
// stalling in any of them while m_tready is low. Throughput: one request
// per cycle when not stalled; each of the six lanes owns its multipliers.
// Reset: rst_n clears all valid bits and loads identity into both matrices.
module affine_transform_apply
    import afx_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int WORD_WIDTH = 32,
    localparam int IN_BITS   = IDX_W + 9 * WORD_WIDTH,
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_W     = 8 * WORD_WIDTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // entry_index, entry_value, in_x, in_y, in_z, in_dx, in_dy, in_dz,
    // in_tmin, in_tmax, zero fill to whole bytes
    input  logic [IN_W-1:0]  s_tdata,
    // cmd
    input  logic [CMD_W-1:0] s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // res_x, res_y, res_z, res_dx, res_dy, res_dz, res_tmin, res_tmax
    output logic [OUT_W-1:0] m_tdata
);

    localparam logic [WORD_WIDTH-1:0] ONE_Q =
        {{(WORD_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;

    // ---------------------------------------------------------------
    // Unpack the input request
    // ---------------------------------------------------------------
    cmd_t                  cmd;
    logic [IDX_W-1:0]      entry_index;
    logic [WORD_WIDTH-1:0] entry_value;
    logic [2:0][WORD_WIDTH-1:0] in_p;
    logic [2:0][WORD_WIDTH-1:0] in_d;
    logic [WORD_WIDTH-1:0] in_tmin;
    logic [WORD_WIDTH-1:0] in_tmax;

    assign cmd         = cmd_t'(s_tuser);
    assign entry_index = s_tdata[IDX_W-1:0];
    assign entry_value = s_tdata[IDX_W +: WORD_WIDTH];
    assign in_p[0]     = s_tdata[IDX_W + 1 * WORD_WIDTH +: WORD_WIDTH];
    assign in_p[1]     = s_tdata[IDX_W + 2 * WORD_WIDTH +: WORD_WIDTH];
    assign in_p[2]     = s_tdata[IDX_W + 3 * WORD_WIDTH +: WORD_WIDTH];
    assign in_d[0]     = s_tdata[IDX_W + 4 * WORD_WIDTH +: WORD_WIDTH];
    assign in_d[1]     = s_tdata[IDX_W + 5 * WORD_WIDTH +: WORD_WIDTH];
    assign in_d[2]     = s_tdata[IDX_W + 6 * WORD_WIDTH +: WORD_WIDTH];
    assign in_tmin     = s_tdata[IDX_W + 7 * WORD_WIDTH +: WORD_WIDTH];
    assign in_tmax     = s_tdata[IDX_W + 8 * WORD_WIDTH +: WORD_WIDTH];

    // ---------------------------------------------------------------
    // Command decode
    // ---------------------------------------------------------------
    logic gives_res;
    logic load_fwd;
    logic load_inv;
    logic is_normal;
    logic use_t;
    logic is_ray;

    always_comb
    begin
        gives_res = 1'b0;
        load_fwd  = 1'b0;
        load_inv  = 1'b0;
        is_normal = 1'b0;
        use_t     = 1'b0;
        is_ray    = 1'b0;
        case (cmd)
            CMD_LOAD_FWD: load_fwd = 1'b1;
            CMD_LOAD_INV: load_inv = 1'b1;
            CMD_POINT:
            begin
                gives_res = 1'b1;
                use_t     = 1'b1;
            end
            CMD_VECTOR:   gives_res = 1'b1;
            CMD_NORMAL:
            begin
                gives_res = 1'b1;
                is_normal = 1'b1;
            end
            CMD_RAY:
            begin
                gives_res = 1'b1;
                use_t     = 1'b1;
                is_ray    = 1'b1;
            end
            default:      gives_res = 1'b0;   // unused codes: drop
        endcase
    end

    // ---------------------------------------------------------------
    // Pipeline flow control: each stage advances when empty or when the
    // stage after it advances. Ready runs combinationally from m_tready to s_tready.
    // ---------------------------------------------------------------
    logic    v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic    rdy1, rdy2, rdy3, rdy4;
    logic    accept;
    afx_en_t lane_en;

    assign rdy4     = !out_valid_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign accept   = s_tvalid && rdy1;

    assign lane_en.en1 = rdy1;
    assign lane_en.en2 = rdy2;
    assign lane_en.en3 = rdy3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= accept && gives_res;   // loads leave no request behind
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // Matrix registers. A load is written at the edge it is taken; the
    // products of any request taken at that edge still see the old entry,
    // and every later request sees the new one, so program order holds.
    // ---------------------------------------------------------------
    logic [WORD_WIDTH-1:0] fwd_reg [FWD_DEPTH];
    logic [WORD_WIDTH-1:0] inv_reg [INV_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FWD_DEPTH; i++)
            begin
                // diagonal of a row-major 3x4 sits at every fifth entry
                fwd_reg[i] <= (i % (FWD_COLS + 1) == 0) ? ONE_Q : '0;
            end
            for (int i = 0; i < INV_DEPTH; i++)
            begin
                inv_reg[i] <= (i % (INV_COLS + 1) == 0) ? ONE_Q : '0;
            end
        end
        else
        begin
            if (accept && load_fwd && (entry_index < IDX_W'(FWD_DEPTH)))
            begin
                fwd_reg[entry_index] <= entry_value;
            end
            if (accept && load_inv && (entry_index < IDX_W'(INV_DEPTH)))
            begin
                inv_reg[entry_index] <= entry_value;
            end
        end
    end

    // ---------------------------------------------------------------
    // Lanes: rows 0..2 for the position (point, vector, normal, ray
    // origin), rows 0..2 again for the ray direction. A normal takes the
    // transposed inverse, so its row r reads inverse column r.
    // ---------------------------------------------------------------
    logic [2:0][2:0][WORD_WIDTH-1:0] coef_p;
    logic [2:0][2:0][WORD_WIDTH-1:0] coef_d;
    logic [2:0][WORD_WIDTH-1:0]      res_p;
    logic [2:0][WORD_WIDTH-1:0]      res_d;

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 3; c++)
        begin : g_col
            assign coef_p[r][c] = is_normal ? inv_reg[c * INV_COLS + r]
                                            : fwd_reg[r * FWD_COLS + c];
            assign coef_d[r][c] = fwd_reg[r * FWD_COLS + c];
        end

        afx_lane #(
            .FRAC_BITS  (FRAC_BITS),
            .WORD_WIDTH (WORD_WIDTH)
        ) u_lane_p (
            .clk   (clk),
            .en    (lane_en),
            .coef  (coef_p[r]),
            .vec   (in_p),
            .trans (fwd_reg[r * FWD_COLS + FWD_COLS - 1]),
            .use_t (use_t),
            .res   (res_p[r])
        );

        afx_lane #(
            .FRAC_BITS  (FRAC_BITS),
            .WORD_WIDTH (WORD_WIDTH)
        ) u_lane_d (
            .clk   (clk),
            .en    (lane_en),
            .coef  (coef_d[r]),
            .vec   (in_d),
            .trans (fwd_reg[r * FWD_COLS + FWD_COLS - 1]),
            .use_t (1'b0),
            .res   (res_d[r])
        );
    end

    // ---------------------------------------------------------------
    // Side payload: ray flag and t limits travel beside the lanes
    // ---------------------------------------------------------------
    logic                  ray1_reg, ray2_reg, ray3_reg;
    logic [WORD_WIDTH-1:0] tmin1_reg, tmin2_reg, tmin3_reg;
    logic [WORD_WIDTH-1:0] tmax1_reg, tmax2_reg, tmax3_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            ray1_reg  <= is_ray;
            tmin1_reg <= in_tmin;
            tmax1_reg <= in_tmax;
        end
        if (rdy2)
        begin
            ray2_reg  <= ray1_reg;
            tmin2_reg <= tmin1_reg;
            tmax2_reg <= tmax1_reg;
        end
        if (rdy3)
        begin
            ray3_reg  <= ray2_reg;
            tmin3_reg <= tmin2_reg;
            tmax3_reg <= tmax2_reg;
        end
    end

    // ---------------------------------------------------------------
    // Output register: zero the ray-only fields for other commands
    // ---------------------------------------------------------------
    logic [OUT_W-1:0] out_data_reg;
    logic [OUT_W-1:0] out_data_next;

    always_comb
    begin
        out_data_next = {
            ray3_reg ? tmax3_reg : '0,
            ray3_reg ? tmin3_reg : '0,
            ray3_reg ? res_d[2]  : '0,
            ray3_reg ? res_d[1]  : '0,
            ray3_reg ? res_d[0]  : '0,
            res_p[2],
            res_p[1],
            res_p[0]
        };
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
